FILE: rtl/rlcum_pkg.sv
package rlcum_pkg;

    localparam int ROW_W      = 32;
    localparam int ROW_BW     = 5;
    localparam int ROW_AW_MAX = 5;
    localparam int SN_FW      = 10;
    localparam int CNT_FW     = 11;
    localparam int TICK_W     = 16;

    localparam logic MODE_PDU  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic             mode;
        logic [SN_FW-1:0] seq_num;
    } item_t;

    typedef struct packed {
        logic              discarded;
        logic [SN_FW-1:0]  deliver_first;
        logic [CNT_FW-1:0] deliver_count;
        logic [SN_FW-1:0]  lowest_unreceived;
        logic [SN_FW-1:0]  highest_next;
        logic              timer_active;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [ROW_AW_MAX-1:0] addr;
        logic [ROW_W-1:0]      wdata;
    } mark_req_t;

    typedef struct packed {
        logic              found;
        logic [ROW_BW-1:0] first;
        logic [ROW_W-1:0]  cleared;
    } row_res_t;

endpackage

FILE: rtl/rlc_um_reordering_window_unit.sv
// channel   direction  handshake          payload
// item      in         start / busy       item.mode, item.seq_num
// result    out        done (one cycle)   result.* (six fields)
// config    in         cfg_we             cfg_data (t-Reordering ticks)
//
// an item is taken when start is high and busy low; one result follows per item:
// a pdu wraps an oversized seq_num, checks and marks its bit, scans the bitmap rows and clears
// delivered bits row by row (a discarded pdu stops early); an expiring tick scans from the trigger;
// the bitmap memory is single-port and the row unit is shared by the scan and the clear
// after reset a clearing pass writes every bitmap row with busy high
// done is high for exactly one cycle; the receiver cannot stall
module rlc_um_reordering_window_unit #(
    parameter int SN_SPACE = 1024,
    parameter int WINDOW   = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rlcum_pkg::item_t              item,
    output logic                          done,
    output rlcum_pkg::result_t            result,
    input  logic                          cfg_we,
    input  logic [rlcum_pkg::TICK_W-1:0]  cfg_data
);
    import rlcum_pkg::*;

    localparam int SW       = $clog2(SN_SPACE);
    localparam int ROWS     = (SN_SPACE + ROW_W - 1) / ROW_W;
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW       = $clog2(ROWS + 1);
    localparam int LW       = ROW_BW + 1;
    localparam int LAST_LEN = SN_SPACE - ROW_W * (ROWS - 1);
    localparam int EFF_WIN  = (WINDOW < SN_SPACE / 2) ? WINDOW : SN_SPACE / 2;

    localparam logic [SW:0]   SN_W   = (SW+1)'(SN_SPACE);
    localparam logic [SW:0]   COMP_W = (SW+1)'(SN_SPACE - EFF_WIN);
    localparam logic [SW-1:0] WIN_W  = SW'(EFF_WIN);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_CHECK, S_ADJ, S_SCAN_RD, S_SCAN_EV,
        S_TMR, S_CLR_RD, S_CLR_WR, S_DONE
    } state_t;

    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a, input logic [SW:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + b;
        if (s >= SN_W)
        begin
            s = s - SN_W;
        end
        return SW'(s);
    endfunction

    function automatic logic [SW-1:0] sub_mod(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] d;
        d = {1'b0, a} + SN_W - {1'b0, b};
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        return SW'(d);
    endfunction

    // position counted forward from the window base
    function automatic logic [SW-1:0] rel(input logic [SW-1:0] v, input logic [SW-1:0] h);
        return add_mod(sub_mod(v, h), COMP_W);
    endfunction

    function automatic logic [RW-1:0] row_of(input logic [SW-1:0] a);
        return RW'(a >> ROW_BW);
    endfunction

    function automatic logic [LW-1:0] len_of(input logic [RW-1:0] r);
        return (r == RW'(ROWS - 1)) ? LW'(LAST_LEN) : LW'(ROW_W);
    endfunction

    state_t             state_reg, state_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [SW-1:0]      low_reg, low_next;
    logic [SW-1:0]      high_reg, high_next;
    logic [SW-1:0]      trig_reg, trig_next;
    logic               trun_reg, trun_next;
    logic [TICK_W-1:0]  tleft_reg, tleft_next;
    logic [SW-1:0]      old_low_reg, old_low_next;
    logic [SN_FW-1:0]   x_reg, x_next;
    logic               kind_reg, kind_next;
    logic               drop_reg, drop_next;
    logic               outwin_reg, outwin_next;
    logic [SW-1:0]      scan_start_reg, scan_start_next;
    logic [RW-1:0]      scan_row_reg, scan_row_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [SW-1:0]      pos_reg, pos_next;
    logic [SW-1:0]      rem_reg, rem_next;
    logic [RW-1:0]      clr_row_reg, clr_row_next;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;

    mark_req_t          mreq;
    logic [ROW_W-1:0]   rd;
    logic [ROW_BW-1:0]  ru_lo;
    logic [LW-1:0]      ru_hi;
    row_res_t           rr;

    logic [SW-1:0]      x_sn;
    logic [ROW_BW-1:0]  x_bit;
    logic [SW-1:0]      rel_x;
    logic [SW-1:0]      rel_low;
    logic [SW-1:0]      rel_trig;
    logic               need_chk;
    logic [TICK_W-1:0]  tleft_dec;
    logic [TICK_W-1:0]  tstart;
    logic [ROW_BW-1:0]  sbit;
    logic [LW-1:0]      scan_len;
    logic [ROW_BW-1:0]  cbit;
    logic [LW-1:0]      clen;
    logic [LW-1:0]      avail;
    logic [LW-1:0]      clr_hi;
    logic [LW-1:0]      clr_n;
    logic [SW-1:0]      low_adj;
    logic               stop;
    logic               run_mid;

    rlcum_mark_mem #(
        .ROWS (ROWS)
    ) u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (rd)
    );

    rlcum_row_unit u_row (
        .data (rd),
        .lo   (ru_lo),
        .hi   (ru_hi),
        .res  (rr)
    );

    assign x_sn      = x_reg[SW-1:0];
    assign x_bit     = x_sn[ROW_BW-1:0];
    assign rel_x     = rel(x_sn, high_reg);
    assign rel_low   = rel(low_reg, high_reg);
    assign rel_trig  = rel(trig_reg, high_reg);
    assign need_chk  = (rel_x > rel_low) && (rel_x < WIN_W);
    assign tleft_dec = (tleft_reg != '0) ? tleft_reg - 1'b1 : '0;
    assign tstart    = (ticks_reg != '0) ? ticks_reg : TICK_W'(1);
    assign sbit      = scan_start_reg[ROW_BW-1:0];
    assign scan_len  = len_of(scan_row_reg);
    assign cbit      = pos_reg[ROW_BW-1:0];
    assign clen      = len_of(row_of(pos_reg));
    assign avail     = clen - {1'b0, cbit};
    assign clr_hi    = (CNT_FW'(rem_reg) >= CNT_FW'(avail)) ? clen
                                                            : {1'b0, cbit} + LW'(rem_reg);
    assign clr_n     = clr_hi - {1'b0, cbit};
    assign low_adj   = (outwin_reg && rel_low >= WIN_W) ? add_mod(high_reg, COMP_W) : low_reg;
    assign stop      = trun_reg && ((rel_trig <= rel_low) ||
                                    (rel_trig >= WIN_W && trig_reg != high_reg));
    assign run_mid   = (kind_reg == MODE_PDU) ? (trun_reg && !stop) : 1'b0;

    // row unit operand select
    always_comb
    begin
        ru_lo = '0;
        ru_hi = scan_len;
        if (state_reg == S_CLR_WR)
        begin
            ru_lo = cbit;
            ru_hi = clr_hi;
        end
        else if (k_reg == '0)
        begin
            ru_lo = sbit;
        end
        else if (k_reg == KW'(ROWS))
        begin
            ru_hi = {1'b0, sbit};
        end
    end

    // bitmap port
    always_comb
    begin
        mreq.we    = 1'b0;
        mreq.addr  = ROW_AW_MAX'(row_of(pos_reg));
        mreq.wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.we   = 1'b1;
                mreq.addr = ROW_AW_MAX'(clr_row_reg);
            end
            S_REDUCE:
            begin
                mreq.addr = ROW_AW_MAX'(row_of(x_sn));
            end
            S_CHECK:
            begin
                mreq.we    = !(need_chk && rd[x_bit]);
                mreq.addr  = ROW_AW_MAX'(row_of(x_sn));
                mreq.wdata = rd | (ROW_W'(1) << x_bit);
            end
            S_SCAN_RD, S_SCAN_EV:
            begin
                mreq.addr = ROW_AW_MAX'(scan_row_reg);
            end
            S_CLR_WR:
            begin
                mreq.we    = 1'b1;
                mreq.wdata = rr.cleared;
            end
            default:
            begin
                mreq.we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        ticks_next      = cfg_we ? cfg_data : ticks_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        trig_next       = trig_reg;
        trun_next       = trun_reg;
        tleft_next      = tleft_reg;
        old_low_next    = old_low_reg;
        x_next          = x_reg;
        kind_next       = kind_reg;
        drop_next       = drop_reg;
        outwin_next     = outwin_reg;
        scan_start_next = scan_start_reg;
        scan_row_next   = scan_row_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        clr_row_next    = clr_row_reg;
        done_next       = 1'b0;
        res_next        = res_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == RW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    old_low_next = low_reg;
                    kind_next    = item.mode;
                    drop_next    = 1'b0;
                    x_next       = item.seq_num;
                    if (item.mode == MODE_PDU)
                    begin
                        state_next = S_REDUCE;
                    end
                    else if (trun_reg && tleft_dec == '0)
                    begin
                        // expiry: search from the trigger
                        tleft_next      = '0;
                        scan_start_next = trig_reg;
                        scan_row_next   = row_of(trig_reg);
                        k_next          = '0;
                        state_next      = S_SCAN_RD;
                    end
                    else
                    begin
                        if (trun_reg)
                        begin
                            tleft_next = tleft_dec;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (CNT_FW'(x_reg) >= CNT_FW'(SN_SPACE))
                begin
                    x_next = SN_FW'(CNT_FW'(x_reg) - CNT_FW'(SN_SPACE));
                end
                else if (rel_x < rel_low)
                begin
                    drop_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (need_chk && rd[x_bit])
                begin
                    drop_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    outwin_next = (rel_x >= WIN_W);
                    if (rel_x >= WIN_W)
                    begin
                        high_next = add_mod(x_sn, (SW+1)'(1));
                    end
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                low_next        = low_adj;
                scan_start_next = low_adj;
                scan_row_next   = row_of(low_adj);
                k_next          = '0;
                state_next      = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (rr.found)
                begin
                    low_next   = SW'({scan_row_reg, rr.first});
                    state_next = S_TMR;
                end
                else if (k_reg == KW'(ROWS))
                begin
                    low_next   = scan_start_reg;
                    state_next = S_TMR;
                end
                else
                begin
                    k_next        = KW'(k_reg + 1'b1);
                    scan_row_next = (scan_row_reg == RW'(ROWS - 1)) ? '0
                                                                    : scan_row_reg + 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_TMR:
            begin
                if (!run_mid && rel_low < WIN_W)
                begin
                    trun_next  = 1'b1;
                    tleft_next = tstart;
                    trig_next  = high_reg;
                end
                else
                begin
                    trun_next = run_mid;
                end
                pos_next   = old_low_reg;
                rem_next   = sub_mod(low_reg, old_low_reg);
                state_next = S_CLR_RD;
            end
            S_CLR_RD:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CLR_WR;
                end
            end
            S_CLR_WR:
            begin
                pos_next   = add_mod(pos_reg, (SW+1)'(clr_n));
                rem_next   = rem_reg - SW'(clr_n);
                state_next = S_CLR_RD;
            end
            S_DONE:
            begin
                done_next                  = 1'b1;
                res_next.discarded         = drop_reg;
                res_next.deliver_first     = SN_FW'(old_low_reg);
                res_next.deliver_count     = CNT_FW'(sub_mod(low_reg, old_low_reg));
                res_next.lowest_unreceived = SN_FW'(low_reg);
                res_next.highest_next      = SN_FW'(high_reg);
                res_next.timer_active      = trun_reg;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ticks_reg      <= TICKS_RESET;
            low_reg        <= '0;
            high_reg       <= '0;
            trig_reg       <= '0;
            trun_reg       <= 1'b0;
            tleft_reg      <= '0;
            old_low_reg    <= '0;
            x_reg          <= '0;
            kind_reg       <= MODE_PDU;
            drop_reg       <= 1'b0;
            outwin_reg     <= 1'b0;
            scan_start_reg <= '0;
            scan_row_reg   <= '0;
            k_reg          <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            clr_row_reg    <= '0;
            done_reg       <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ticks_reg      <= ticks_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            trig_reg       <= trig_next;
            trun_reg       <= trun_next;
            tleft_reg      <= tleft_next;
            old_low_reg    <= old_low_next;
            x_reg          <= x_next;
            kind_reg       <= kind_next;
            drop_reg       <= drop_next;
            outwin_reg     <= outwin_next;
            scan_start_reg <= scan_start_next;
            scan_row_reg   <= scan_row_next;
            k_reg          <= k_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            clr_row_reg    <= clr_row_next;
            done_reg       <= done_next;
            res_reg        <= res_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while an item is in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start processing");

    a_timer_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && trun_reg) |-> (tleft_reg != '0))
        else $error("timer running with no ticks left");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_EV) |-> (k_reg <= KW'(ROWS)))
        else $error("bitmap scan ran past a full lap");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.deliver_count < CNT_FW'(SN_SPACE)))
        else $error("delivery range longer than the sequence space");

endmodule

FILE: rtl/rlcum_mark_mem.sv
module rlcum_mark_mem #(
    parameter int ROWS = 32
) (
    input  logic                         clk,
    input  rlcum_pkg::mark_req_t         req,
    output logic [rlcum_pkg::ROW_W-1:0]  rdata
);
    import rlcum_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[RW-1:0]] <= req.wdata;
        end
        rdata_reg <= mem[req.addr[RW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rlcum_row_unit.sv
module rlcum_row_unit (
    input  logic [rlcum_pkg::ROW_W-1:0]  data,
    input  logic [rlcum_pkg::ROW_BW-1:0] lo,
    input  logic [rlcum_pkg::ROW_BW:0]   hi,
    output rlcum_pkg::row_res_t          res
);
    import rlcum_pkg::*;

    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] cand;

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            mask[i] = ((ROW_BW+1)'(i) >= {1'b0, lo}) && ((ROW_BW+1)'(i) < hi);
        end
        cand = ~data & mask;
    end

    // lowest unmarked position inside the range
    always_comb
    begin
        res.found   = |cand;
        res.first   = '0;
        res.cleared = data & ~mask;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                res.first = ROW_BW'(i);
            end
        end
    end

endmodule
